### sv/slsfp_pkg.sv
// Shared types and constants for the sync/length/checksum frame parser.
// No dependencies; imported by every module of the parser.
`timescale 1ns / 1ps

package slsfp_pkg;

   localparam int unsigned DEFAULT_MAX_PAYLOAD = 256;

   localparam logic [7:0] SYNC_FIRST  = 8'h55;
   localparam logic [7:0] SYNC_SECOND = 8'hAA;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_GOOD     = 2'd1,
      KIND_BAD_SUM  = 2'd2,
      KIND_OVERFLOW = 2'd3
   } kind_type;

   typedef enum logic [7:0] {
      PH_HUNT  = 8'b0000_0001,
      PH_SYNC2 = 8'b0000_0010,
      PH_VER   = 8'b0000_0100,
      PH_CMD   = 8'b0000_1000,
      PH_LENHI = 8'b0001_0000,
      PH_LENLO = 8'b0010_0000,
      PH_DATA  = 8'b0100_0000,
      PH_SUM   = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic        emit;
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic [7:0]  byte_index;
      logic [7:0]  frame_version;
      logic [7:0]  frame_command;
      logic [15:0] frame_length;
      logic        end_of_frame;
   } result_type;

endpackage

### sv/sync_length_sum_frame_parser_unit.sv
// Top level of the sync/length/checksum frame parser.
// Depends on slsfp_pkg, slsfp_in_reg, slsfp_core and slsfp_out_reg.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_rx_byte
//   rsp     | out       | rsp_valid/rsp_stall  | kind, byte, index, header fields, eof
//
// One byte beat per cycle sustained while rsp_stall is low; a beat is held in the input
// register and its result is loaded into the result register when the core takes it.
// Header bytes and dropped sync bytes give no result beat, but a too-long length does.
// Synchronous active-high reset returns the parser to sync hunting.
// A stalled result register holds its beat and freezes the core; req_stall
// follows rsp_stall in the same cycle while the input register holds a beat,
// otherwise after the one beat the input register can still take.
`timescale 1ns / 1ps

module sync_length_sum_frame_parser_unit #(
   parameter int unsigned MAX_PAYLOAD = slsfp_pkg::DEFAULT_MAX_PAYLOAD
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_rx_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output slsfp_pkg::kind_type rsp_kind,
   output logic [7:0]          rsp_payload_byte,
   output logic [7:0]          rsp_byte_index,
   output logic [7:0]          rsp_frame_version,
   output logic [7:0]          rsp_frame_command,
   output logic [15:0]         rsp_frame_length,
   output logic                rsp_end_of_frame
);
   import slsfp_pkg::*;

   logic       held_valid;
   logic [7:0] held_byte;
   logic       out_ready;
   logic       take;
   result_type result;

   assign take = held_valid && out_ready;

   slsfp_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .take        (take),
      .held_valid  (held_valid),
      .held_byte   (held_byte)
   );

   slsfp_core #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (held_byte),
      .result  (result)
   );

   slsfp_out_reg u_out_reg (
      .clock             (clock),
      .reset             (reset),
      .result            (result),
      .ready             (out_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_frame_version (rsp_frame_version),
      .rsp_frame_command (rsp_frame_command),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_end_of_frame  (rsp_end_of_frame)
   );

endmodule

### sv/slsfp_in_reg.sv
// Input register stage of the frame parser: holds one received beat.
// Depends on slsfp_pkg.
`timescale 1ns / 1ps

module slsfp_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_rx_byte,
   output logic       req_stall,
   input  logic       take,
   output logic       held_valid,
   output logic [7:0] held_byte
);
   import slsfp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   assign req_stall  = valid_ff && !take;
   assign accept     = req_valid && !req_stall;
   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register, load on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_rx_byte;
      end
   end

endmodule

### sv/slsfp_core.sv
// Frame parse state and per-beat update logic of the frame parser.
// Depends on slsfp_pkg.
`timescale 1ns / 1ps

module slsfp_core #(
   parameter int unsigned MAX_PAYLOAD = slsfp_pkg::DEFAULT_MAX_PAYLOAD
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic [7:0]             rx_byte,
   output slsfp_pkg::result_type  result
);
   import slsfp_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

   phase_type        phase_ff, phase_in;
   logic [7:0]       ver_ff, ver_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [15:0]      len_ff, len_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       sum_ff, sum_in;
   logic [CNT_W:0]   count_next;
   logic [15:0]      count_wide;

   assign count_next = {1'b0, count_ff} + {{CNT_W{1'b0}}, 1'b1};
   assign count_wide = 16'(count_ff);

   always_comb begin
      phase_in = phase_ff;
      ver_in   = ver_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      result   = '0;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == SYNC_FIRST) begin
               sum_in   = rx_byte;
               phase_in = PH_SYNC2;
            end
         end
         PH_SYNC2: begin
            if (rx_byte == SYNC_SECOND) begin
               sum_in   = sum_ff + rx_byte;
               phase_in = PH_VER;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_VER: begin
            ver_in   = rx_byte;
            sum_in   = sum_ff + rx_byte;
            phase_in = PH_CMD;
         end
         PH_CMD: begin
            cmd_in   = rx_byte;
            sum_in   = sum_ff + rx_byte;
            phase_in = PH_LENHI;
         end
         PH_LENHI: begin
            len_in   = {rx_byte, 8'h00};
            sum_in   = sum_ff + rx_byte;
            phase_in = PH_LENLO;
         end
         PH_LENLO: begin
            len_in   = {len_ff[15:8], rx_byte};
            sum_in   = sum_ff + rx_byte;
            count_in = '0;
            if ({1'b0, len_in} > MAX_LEN) begin
               phase_in            = PH_HUNT;
               result.emit         = 1'b1;
               result.kind         = KIND_OVERFLOW;
               result.end_of_frame = 1'b1;
            end else if (len_in == 16'd0) begin
               phase_in = PH_SUM;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            sum_in              = sum_ff + rx_byte;
            result.emit         = 1'b1;
            result.kind         = KIND_PAYLOAD;
            result.payload_byte = rx_byte;
            result.byte_index   = count_wide[7:0];
            count_in            = count_next[CNT_W-1:0];
            if (16'(count_next) >= len_ff) begin
               phase_in = PH_SUM;
            end
         end
         PH_SUM: begin
            phase_in            = PH_HUNT;
            result.emit         = 1'b1;
            result.kind         = (rx_byte == sum_ff) ? KIND_GOOD : KIND_BAD_SUM;
            result.end_of_frame = 1'b1;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
      result.emit          = result.emit && take;
      result.frame_version = ver_in;
      result.frame_command = cmd_in;
      result.frame_length  = len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         ver_ff   <= '0;
         cmd_ff   <= '0;
         len_ff   <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         ver_ff   <= ver_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

endmodule

### sv/slsfp_out_reg.sv
// Result register of the frame parser: holds one result beat for the consumer.
// Depends on slsfp_pkg.
`timescale 1ns / 1ps

module slsfp_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  slsfp_pkg::result_type result,
   output logic                  ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output slsfp_pkg::kind_type   rsp_kind,
   output logic [7:0]            rsp_payload_byte,
   output logic [7:0]            rsp_byte_index,
   output logic [7:0]            rsp_frame_version,
   output logic [7:0]            rsp_frame_command,
   output logic [15:0]           rsp_frame_length,
   output logic                  rsp_end_of_frame
);
   import slsfp_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   assign ready             = !valid_ff || !rsp_stall;
   assign rsp_valid         = valid_ff;
   assign rsp_kind          = data_ff.kind;
   assign rsp_payload_byte  = data_ff.payload_byte;
   assign rsp_byte_index    = data_ff.byte_index;
   assign rsp_frame_version = data_ff.frame_version;
   assign rsp_frame_command = data_ff.frame_command;
   assign rsp_frame_length  = data_ff.frame_length;
   assign rsp_end_of_frame  = data_ff.end_of_frame;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= result.emit;
      end
   end

   // hold while stalled, load a new beat only when one is emitted
   always_ff @(posedge clock) begin
      if (ready && result.emit) begin
         data_ff <= result;
      end
   end

endmodule
